@@ rtl/core/periodic_task_scheduler_table_assert.svh @@
// ----------------------------------------------------------------------------
// Periodic task scheduler table - assertion macros
// Concurrent assertion wrappers; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PTST_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler table assertion failed");

// next-cycle implication
`define PTST_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler table assertion failed");

`else

`define PTST_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PTST_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic task scheduler table - package
// Command and result codes, field widths and fixed limits.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam int CMD_W    = 2;
   localparam int KIND_W   = 2;
   localparam int ID_W     = 4;
   localparam int PERIOD_W = 31;
   localparam int TIME_W   = 32;

   // fires allowed per tick pass
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD  = 2'd0,
      CMD_DEL  = 2'd1,
      CMD_TICK = 2'd2
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INIT = 2'd0,
      KIND_RUN  = 2'd1,
      KIND_FULL = 2'd2
   } kind_type;

endpackage

@@ rtl/core/pts_free_find.sv @@
// ----------------------------------------------------------------------------
// Periodic task scheduler table - free slot finder
// Priority encoder returning the lowest unused slot.
// ----------------------------------------------------------------------------
module pts_free_find #(
   parameter int NUM_SLOTS = 16,
   parameter int SLOT_W    = 4
) (
   input  logic [NUM_SLOTS-1:0] used,
   output logic                 found,
   output logic [SLOT_W-1:0]    slot
);

   always_comb begin
      found = 1'b0;
      slot  = '0;
      // scan downward so the lowest free index wins
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!used[i]) begin
            found = 1'b1;
            slot  = SLOT_W'(i);
         end
      end
   end

endmodule

@@ rtl/core/periodic_task_scheduler_table.sv @@
// ----------------------------------------------------------------------------
// Periodic task scheduler table
// Linked table of periodic tasks held in two synchronous memories; add,
// delete and tick commands, tick walks the list and reports each fire.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  req_*     in    req_valid/req_ready    cmd, task_id, period, has_handler, now
//  rsp_*     out   rsp_valid/rsp_ready    kind, slot, time_now, task_period, last
//
//  Add: the result passes through the holding and output registers.
//  Delete: walks the links from the head to the task; an unknown id is dropped.
//  Tick: visits the list entries in turn, up to MAX_TASKS, through the
//  single read port walking the links.
//  A fire stalls the walk while results wait in both the output and holding
//  registers; the next transfer waits until the holding register is empty.
//  Reset is synchronous; it clears the state, used bits, list head and valid flags.
// ----------------------------------------------------------------------------
`include "periodic_task_scheduler_table_assert.svh"

module periodic_task_scheduler_table #(
   parameter int MAX_TASKS = 16
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [pts_pkg::CMD_W-1:0]     req_cmd,
   input  logic [pts_pkg::ID_W-1:0]      req_task_id,
   input  logic [pts_pkg::PERIOD_W-1:0]  req_period,
   input  logic                          req_has_handler,
   input  logic [pts_pkg::TIME_W-1:0]    req_now,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pts_pkg::KIND_W-1:0]    rsp_kind,
   output logic [pts_pkg::ID_W-1:0]      rsp_slot,
   output logic [pts_pkg::TIME_W-1:0]    rsp_time_now,
   output logic [pts_pkg::PERIOD_W-1:0]  rsp_task_period,
   output logic                          rsp_last
);

   import pts_pkg::*;

   localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int LINK_W = $clog2(MAX_TASKS + 1);
   localparam int IDX_W  = LINK_W + ID_W;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_TASKS);
   localparam logic [LINK_W-1:0] LAST_STEP = LINK_W'(MAX_TASKS - 1);
   localparam logic [CNT_W-1:0]  LAST_FIRE = CNT_W'(MAX_RESULTS - 1);

   typedef struct packed {
      logic                handler;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   wakeup;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DEL
   } state_type;

   // entry memories
   entry_type           task_mem [MAX_TASKS];
   logic [LINK_W-1:0]   link_mem [MAX_TASKS];
   entry_type           task_rd_ff;
   logic [LINK_W-1:0]   link_rd_ff;

   // control
   state_type           state_ff;
   logic [MAX_TASKS-1:0] used_ff;
   logic [LINK_W-1:0]   head_ff;
   logic [LINK_W-1:0]   cur_ff;
   logic [LINK_W-1:0]   prev_ff;
   logic [LINK_W-1:0]   del_id_ff;
   logic [LINK_W-1:0]   step_ff;
   logic [CNT_W-1:0]    fire_cnt_ff;
   logic [TIME_W-1:0]   now_ff;

   // holding register: the newest result, kept until its last flag is known
   logic                pend_valid_ff;
   logic                pend_last_ff;
   kind_type            pend_kind_ff;
   logic [SLOT_W-1:0]   pend_slot_ff;
   logic [TIME_W-1:0]   pend_time_ff;
   logic [PERIOD_W-1:0] pend_period_ff;

   // output register
   logic                rsp_valid_ff;
   kind_type            rsp_kind_ff;
   logic [ID_W-1:0]     rsp_slot_ff;
   logic [TIME_W-1:0]   rsp_time_ff;
   logic [PERIOD_W-1:0] rsp_period_ff;
   logic                rsp_last_ff;

   logic                req_xfer;
   logic                out_free;
   logic                free_found;
   logic [SLOT_W-1:0]   free_slot;
   logic [IDX_W-1:0]    id_ext;
   logic                id_ok;
   logic [TIME_W:0]     wake_sum;
   logic [TIME_W-1:0]   wake_new;
   logic                due;
   logic                stall;
   logic                walk_done;
   logic                del_hit;
   logic                drain;
   logic                push;
   logic                rsp_load;
   logic [SLOT_W+ID_W-1:0] slot_wide;
   logic                is_add;
   logic [LINK_W-1:0]   rd_addr;
   logic                task_we;
   logic [SLOT_W-1:0]   task_waddr;
   entry_type           task_wdata;
   logic                link_we;
   logic [SLOT_W-1:0]   link_waddr;
   logic [LINK_W-1:0]   link_wdata;

   pts_free_find #(
      .NUM_SLOTS (MAX_TASKS),
      .SLOT_W    (SLOT_W)
   ) u_free_find (
      .used  (used_ff),
      .found (free_found),
      .slot  (free_slot)
   );

   assign req_ready = (state_ff == ST_IDLE) && !pend_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_add    = req_xfer && (cmd_type'(req_cmd) == CMD_ADD);

   assign id_ext = IDX_W'(req_task_id);
   assign id_ok  = (id_ext < IDX_W'(MAX_TASKS)) && used_ff[id_ext[SLOT_W-1:0]];

   // wakeup update, saturating at the top of the time range
   assign wake_sum = {1'b0, now_ff} + (TIME_W + 1)'(task_rd_ff.period);
   assign wake_new = wake_sum[TIME_W] ? '1 : wake_sum[TIME_W-1:0];

   assign due       = (state_ff == ST_WALK) && task_rd_ff.handler
                      && (now_ff >= task_rd_ff.wakeup);
   assign stall     = due && pend_valid_ff && !out_free;
   assign walk_done = (link_rd_ff == NULL_LINK) || (step_ff == LAST_STEP)
                      || (due && (fire_cnt_ff == LAST_FIRE));
   assign del_hit   = (cur_ff == del_id_ff);

   // pend moves out either when it is known last or when a newer fire displaces it
   assign drain    = pend_valid_ff && pend_last_ff && out_free;
   assign push     = due && !stall && pend_valid_ff;
   assign rsp_load = drain || push;

   assign slot_wide = (SLOT_W + ID_W)'(pend_slot_ff);

   always_comb begin
      unique case (state_ff)
         ST_IDLE: rd_addr = head_ff;
         ST_WALK: rd_addr = stall ? cur_ff : link_rd_ff;
         ST_DEL:  rd_addr = link_rd_ff;
         default: rd_addr = head_ff;
      endcase
   end

   always_comb begin
      if (state_ff == ST_IDLE) begin
         task_we    = is_add && free_found;
         task_waddr = free_slot;
         task_wdata = '{handler: req_has_handler, period: req_period, wakeup: req_now};
         link_we    = is_add && free_found;
         link_waddr = free_slot;
         link_wdata = head_ff;
      end else begin
         task_we    = due && !stall;
         task_waddr = cur_ff[SLOT_W-1:0];
         task_wdata = '{handler: task_rd_ff.handler, period: task_rd_ff.period,
                        wakeup: wake_new};
         link_we    = (state_ff == ST_DEL) && del_hit && (prev_ff != NULL_LINK);
         link_waddr = prev_ff[SLOT_W-1:0];
         link_wdata = link_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (task_we) begin
         task_mem[task_waddr] <= task_wdata;
      end
      task_rd_ff <= task_mem[rd_addr[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[rd_addr[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         head_ff       <= NULL_LINK;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_kind_ff   <= pend_kind_ff;
            rsp_slot_ff   <= slot_wide[ID_W-1:0];
            rsp_time_ff   <= pend_time_ff;
            rsp_period_ff <= pend_period_ff;
            rsp_last_ff   <= pend_last_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (drain) begin
            pend_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  now_ff <= req_now;
                  case (cmd_type'(req_cmd))
                     CMD_ADD: begin
                        pend_valid_ff  <= 1'b1;
                        pend_last_ff   <= 1'b1;
                        pend_time_ff   <= req_now;
                        pend_period_ff <= req_period;
                        if (free_found) begin
                           used_ff[free_slot] <= 1'b1;
                           head_ff            <= LINK_W'(free_slot);
                           pend_kind_ff       <= KIND_INIT;
                           pend_slot_ff       <= free_slot;
                        end else begin
                           pend_kind_ff <= KIND_FULL;
                           pend_slot_ff <= '0;
                        end
                     end
                     CMD_DEL: begin
                        if (id_ok) begin
                           del_id_ff <= id_ext[LINK_W-1:0];
                           cur_ff    <= head_ff;
                           prev_ff   <= NULL_LINK;
                           state_ff  <= ST_DEL;
                        end
                     end
                     CMD_TICK: begin
                        if (head_ff != NULL_LINK) begin
                           cur_ff      <= head_ff;
                           step_ff     <= '0;
                           fire_cnt_ff <= '0;
                           state_ff    <= ST_WALK;
                        end
                     end
                     default: ;
                  endcase
               end
            end

            ST_WALK: begin
               if (!stall) begin
                  if (due) begin
                     pend_valid_ff  <= 1'b1;
                     pend_last_ff   <= walk_done;
                     pend_kind_ff   <= KIND_RUN;
                     pend_slot_ff   <= cur_ff[SLOT_W-1:0];
                     pend_time_ff   <= now_ff;
                     pend_period_ff <= task_rd_ff.period;
                     fire_cnt_ff    <= fire_cnt_ff + 1'b1;
                  end
                  if (walk_done) begin
                     // whatever is held now closes the pass
                     if (!due) begin
                        pend_last_ff <= 1'b1;
                     end
                     state_ff     <= ST_IDLE;
                  end else begin
                     cur_ff  <= link_rd_ff;
                     step_ff <= step_ff + 1'b1;
                  end
               end
            end

            ST_DEL: begin
               if (del_hit) begin
                  if (prev_ff == NULL_LINK) begin
                     head_ff <= link_rd_ff;
                  end
                  used_ff[del_id_ff[SLOT_W-1:0]] <= 1'b0;
                  state_ff <= ST_IDLE;
               end else if (link_rd_ff == NULL_LINK) begin
                  state_ff <= ST_IDLE;
               end else begin
                  prev_ff <= cur_ff;
                  cur_ff  <= link_rd_ff;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_time_now    = rsp_time_ff;
   assign rsp_task_period = rsp_period_ff;
   assign rsp_last        = rsp_last_ff;

   // list head is null exactly when no slot is in use
   `PTST_ASSERT_IMP(a_head_matches_used, clock, reset, 1'b1, (head_ff == NULL_LINK) == (used_ff == '0))
   // a walk never sits on the null link
   `PTST_ASSERT_IMP(a_walk_not_null, clock, reset, state_ff != ST_IDLE, cur_ff != NULL_LINK)
   // init and full results are always the only result of their item
   `PTST_ASSERT_IMP(a_single_is_last, clock, reset, rsp_valid_ff && (rsp_kind_ff != KIND_RUN), rsp_last_ff)
   // the deleted slot is free once the walk reaches it
   `PTST_ASSERT_NXT(a_del_frees, clock, reset, (state_ff == ST_DEL) && del_hit, !used_ff[del_id_ff[SLOT_W-1:0]])

endmodule
